[rtl/tsp_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and item types of the trapezoid step profile planner.
// Depends on nothing; every other file imports it.
package tsp_pkg;

  // Field widths of one segment and one profile result
  localparam int STEP_W = 24;
  localparam int LEN_W  = 32;
  localparam int SPD_W  = 32;
  localparam int NOM_W  = 20;
  localparam int ACC_W  = 24;
  localparam int AXIS_W = 2;
  localparam int RATE_W = 48;

  // Axis step counts present on the ports
  localparam int NUM_AXES_MAX = 4;

  // Rate stage arithmetic: steps^2 * speed^2 * 2^32 / length^2
  localparam int SQ_W        = 2 * STEP_W;
  localparam int LSQ_W       = 2 * LEN_W;
  localparam int PP_W        = STEP_W + SPD_W;
  localparam int PROD_W      = SQ_W + SPD_W;
  localparam int RATE_SHIFT  = 32;
  localparam int RATE_NUM_W  = PROD_W + RATE_SHIFT;
  localparam int CAP_SHIFT   = 8;

  // Ramp stage arithmetic: divide by accel * 512
  localparam int ACC_SHIFT   = 9;
  localparam int RAMP_DIV_W  = ACC_W + ACC_SHIFT;
  localparam int RAMP_Q_W    = 39;
  localparam int RAMP_NUM_W  = 57;
  localparam int MEET_W      = RAMP_NUM_W + 1;
  localparam int RAMP_LANES  = 3;

  // Ramp divider lanes
  localparam int LANE_UP   = 0;
  localparam int LANE_DOWN = 1;
  localparam int LANE_MEET = 2;

  // Rate divider lanes
  localparam int LANE_ENTRY = 0;
  localparam int LANE_EXIT  = 1;
  localparam int RATE_LANES = 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified segment, as handed from front to back
  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic [AXIS_W-1:0] axis;
    logic              len_zero;
    logic [LEN_W-1:0]  len;
    logic [SPD_W-1:0]  entry_sqr;
    logic [SPD_W-1:0]  exit_sqr;
    logic [RATE_W-1:0] cap;
    logic [ACC_W-1:0]  accel;
  } seg_t;

  // Fields carried alongside the rate divider
  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic [AXIS_W-1:0] axis;
    logic              len_zero;
    logic [RATE_W-1:0] cap;
    logic [ACC_W-1:0]  accel;
    logic [SQ_W-1:0]   a_s;
  } rate_side_t;

  // Fields carried alongside the ramp divider
  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic [AXIS_W-1:0] axis;
    logic              len_zero;
    logic [RATE_W-1:0] er;
    logic [RATE_W-1:0] xr;
    logic              acc_zero;
  } ramp_side_t;

endpackage

[rtl/tsp_front.sv]
`timescale 1ns / 1ps
// Front end: accepts segments, picks the longest axis, flags zero length, forms rate cap.
// Depends on tsp_pkg.
module tsp_front #(
  parameter int AXES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tsp_pkg::STEP_W-1:0] axis0_steps,
  input  logic [tsp_pkg::STEP_W-1:0] axis1_steps,
  input  logic [tsp_pkg::STEP_W-1:0] axis2_steps,
  input  logic [tsp_pkg::STEP_W-1:0] axis3_steps,
  input  logic [tsp_pkg::LEN_W-1:0]  line_length,
  input  logic [tsp_pkg::SPD_W-1:0]  entry_speed_sqr,
  input  logic [tsp_pkg::SPD_W-1:0]  exit_speed_sqr,
  input  logic [tsp_pkg::NOM_W-1:0]  nominal_rate,
  input  logic [tsp_pkg::ACC_W-1:0]  accel_rate,
  output logic                       seg_valid,
  input  logic                       seg_ready,
  output tsp_pkg::seg_t              seg
);
  import tsp_pkg::*;

  localparam int SCAN = (AXES < NUM_AXES_MAX) ? AXES : NUM_AXES_MAX;

  logic [STEP_W-1:0]  axis_steps [NUM_AXES_MAX];
  logic [STEP_W-1:0]  best_steps;
  logic [AXIS_W-1:0]  best_axis;
  logic [2*NOM_W-1:0] nom_sq;
  seg_t               seg_next;

  assign axis_steps[0] = axis0_steps;
  assign axis_steps[1] = axis1_steps;
  assign axis_steps[2] = axis2_steps;
  assign axis_steps[3] = axis3_steps;

  // Scan the axes; a strictly larger count wins, so ties keep the lower index
  always_comb begin
    best_steps = axis_steps[0];
    best_axis  = '0;
    for (int i = 1; i < NUM_AXES_MAX; i++) begin
      if (i < SCAN && best_steps < axis_steps[i]) begin
        best_steps = axis_steps[i];
        best_axis  = AXIS_W'(i);
      end
    end
  end

  // Square the nominal rate into the Q40.8 cap
  assign nom_sq = nominal_rate * nominal_rate;

  always_comb begin
    seg_next.steps     = best_steps;
    seg_next.axis      = best_axis;
    seg_next.len_zero  = (line_length == '0);
    seg_next.len       = line_length;
    seg_next.entry_sqr = entry_speed_sqr;
    seg_next.exit_sqr  = exit_speed_sqr;
    seg_next.cap       = {nom_sq, {CAP_SHIFT{1'b0}}};
    seg_next.accel     = accel_rate;
  end

  // Hold the classified item until the queue takes it
  assign in_ready = !seg_valid || seg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (in_ready) begin
      seg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg <= seg_next;
    end
  end

endmodule

[rtl/tsp_queue.sv]
`timescale 1ns / 1ps
// Short item queue that decouples the front end from the back end.
// Depends on tsp_pkg.
module tsp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tsp_pkg::seg_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tsp_pkg::seg_t pop_data
);
  import tsp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  seg_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/tsp_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
// Depends on tsp_pkg for the house import only; widths come from parameters.
module tsp_div #(
  parameter int LANES = 2,
  parameter int NW    = 112,
  parameter int DW    = 64,
  parameter int QW    = 48,
  parameter int SW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   dividend,
  input  logic [DW-1:0]              divisor,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quot,
  output logic [LANES-1:0]           ovf,
  output logic [LANES-1:0]           rem_nz,
  output logic [SW-1:0]              out_side
);
  import tsp_pkg::*;

  // Remainder and shifting dividend/quotient word of each stage
  logic                          s_valid [QW];
  logic [LANES-1:0][DW-1:0]      s_rem   [QW];
  logic [LANES-1:0][QW-1:0]      s_ql    [QW];
  logic [LANES-1:0]              s_ovf   [QW];
  logic [DW-1:0]                 s_div   [QW];
  logic [SW-1:0]                 s_side  [QW];

  logic [LANES-1:0][DW-1:0]      in_rem;
  logic [LANES-1:0][QW-1:0]      in_ql;
  logic [LANES-1:0]              in_ovf;

  // Split each dividend; a high part not below the divisor means the quotient overflows
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      in_rem[l] = DW'(dividend[l][NW-1:QW]);
      in_ql[l]  = dividend[l][QW-1:0];
      in_ovf[l] = (in_rem[l] >= divisor);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     p_valid;
    logic [LANES-1:0][DW-1:0] p_rem;
    logic [LANES-1:0][QW-1:0] p_ql;
    logic [LANES-1:0]         p_ovf;
    logic [DW-1:0]            p_div;
    logic [SW-1:0]            p_side;
    logic [LANES-1:0][DW-1:0] n_rem;
    logic [LANES-1:0][QW-1:0] n_ql;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = in_rem;
      assign p_ql    = in_ql;
      assign p_ovf   = in_ovf;
      assign p_div   = divisor;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = s_valid[k-1];
      assign p_rem   = s_rem[k-1];
      assign p_ql    = s_ql[k-1];
      assign p_ovf   = s_ovf[k-1];
      assign p_div   = s_div[k-1];
      assign p_side  = s_side[k-1];
    end

    // Shift in the next dividend bit and subtract the divisor when it fits
    always_comb begin
      logic [DW:0] trial;
      logic        qbit;
      for (int l = 0; l < LANES; l++) begin
        trial = {p_rem[l], p_ql[l][QW-1]};
        qbit  = (trial >= {1'b0, p_div});
        if (qbit) begin
          n_rem[l] = DW'(trial - {1'b0, p_div});
        end else begin
          n_rem[l] = DW'(trial);
        end
        n_ql[l] = {p_ql[l][QW-2:0], qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[k] <= 1'b0;
      end else if (en) begin
        s_valid[k] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k]  <= n_rem;
        s_ql[k]   <= n_ql;
        s_ovf[k]  <= p_ovf;
        s_div[k]  <= p_div;
        s_side[k] <= p_side;
      end
    end
  end

  assign out_valid = s_valid[QW-1];
  assign quot      = s_ql[QW-1];
  assign ovf       = s_ovf[QW-1];
  assign out_side  = s_side[QW-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_nz[l] = |s_rem[QW-1][l];
    end
  end

endmodule

[rtl/tsp_back.sv]
`timescale 1ns / 1ps
// Back end: squared step rates, ramp lengths, plateau bounds and the output register.
// Depends on tsp_pkg and tsp_div.
module tsp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tsp_pkg::seg_t              seg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tsp_pkg::AXIS_W-1:0] longest_axis,
  output logic [tsp_pkg::STEP_W-1:0] plateau_start_step,
  output logic [tsp_pkg::STEP_W-1:0] decel_start_step,
  output logic [tsp_pkg::RATE_W-1:0] entry_rate_sqr,
  output logic [tsp_pkg::RATE_W-1:0] exit_rate_sqr,
  output logic                       length_error
);
  import tsp_pkg::*;

  logic en;

  // Whole pipeline moves whenever the output register is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 0: squares and accel*steps
  logic              b0_valid;
  seg_t              b0_seg;
  logic [SQ_W-1:0]   b0_s_sq;
  logic [LSQ_W-1:0]  b0_l_sq;
  logic [SQ_W-1:0]   b0_a_s;
  logic [SQ_W-1:0]   s_sq;
  logic [LSQ_W-1:0]  l_sq;
  logic [SQ_W-1:0]   a_s;

  assign s_sq = seg.steps * seg.steps;
  assign l_sq = seg.len * seg.len;
  assign a_s  = seg.accel * seg.steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
    end else if (en) begin
      b0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_seg  <= seg;
      b0_s_sq <= s_sq;
      b0_l_sq <= l_sq;
      b0_a_s  <= a_s;
    end
  end

  // Stage 1: partial products of steps^2 times each squared speed
  logic              b1_valid;
  seg_t              b1_seg;
  logic [LSQ_W-1:0]  b1_l_sq;
  logic [SQ_W-1:0]   b1_a_s;
  logic [PP_W-1:0]   b1_e_lo;
  logic [PP_W-1:0]   b1_e_hi;
  logic [PP_W-1:0]   b1_x_lo;
  logic [PP_W-1:0]   b1_x_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= b0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_seg  <= b0_seg;
      b1_l_sq <= b0_l_sq;
      b1_a_s  <= b0_a_s;
      b1_e_lo <= b0_s_sq[STEP_W-1:0] * b0_seg.entry_sqr;
      b1_e_hi <= b0_s_sq[SQ_W-1:STEP_W] * b0_seg.entry_sqr;
      b1_x_lo <= b0_s_sq[STEP_W-1:0] * b0_seg.exit_sqr;
      b1_x_hi <= b0_s_sq[SQ_W-1:STEP_W] * b0_seg.exit_sqr;
    end
  end

  // Stage 2: sum partial products into the rate numerators
  logic              b2_valid;
  logic [PROD_W-1:0] b2_num_e;
  logic [PROD_W-1:0] b2_num_x;
  logic [LSQ_W-1:0]  b2_l_sq;
  rate_side_t        b2_side;
  rate_side_t        b2_side_next;

  always_comb begin
    b2_side_next.steps    = b1_seg.steps;
    b2_side_next.axis     = b1_seg.axis;
    b2_side_next.len_zero = b1_seg.len_zero;
    b2_side_next.cap      = b1_seg.cap;
    b2_side_next.accel    = b1_seg.accel;
    b2_side_next.a_s      = b1_a_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (en) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_num_e <= (PROD_W'(b1_e_hi) << STEP_W) + PROD_W'(b1_e_lo);
      b2_num_x <= (PROD_W'(b1_x_hi) << STEP_W) + PROD_W'(b1_x_lo);
      b2_l_sq  <= b1_l_sq;
      b2_side  <= b2_side_next;
    end
  end

  // Rate division by length squared, entry and exit in parallel lanes
  logic [RATE_LANES-1:0][RATE_NUM_W-1:0] rate_num;
  logic                                  rate_valid;
  logic [RATE_LANES-1:0][RATE_W-1:0]     rate_q;
  logic [RATE_LANES-1:0]                 rate_ovf;
  rate_side_t                            rate_side;

  assign rate_num[LANE_ENTRY] = {b2_num_e, {RATE_SHIFT{1'b0}}};
  assign rate_num[LANE_EXIT]  = {b2_num_x, {RATE_SHIFT{1'b0}}};

  tsp_div #(
    .LANES (RATE_LANES),
    .NW    (RATE_NUM_W),
    .DW    (LSQ_W),
    .QW    (RATE_W),
    .SW    ($bits(rate_side_t))
  ) u_rate_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b2_valid),
    .dividend  (rate_num),
    .divisor   (b2_l_sq),
    .in_side   (b2_side),
    .out_valid (rate_valid),
    .quot      (rate_q),
    .ovf       (rate_ovf),
    .rem_nz    (),
    .out_side  (rate_side)
  );

  // Stage 3: clamp rates at the cap, start the meeting-point numerator
  logic              b3_valid;
  logic [RATE_W-1:0] b3_er;
  logic [RATE_W-1:0] b3_xr;
  logic [MEET_W-1:0] b3_pos;
  rate_side_t        b3_side;
  logic [RATE_W-1:0] er_next;
  logic [RATE_W-1:0] xr_next;

  always_comb begin
    if (rate_ovf[LANE_ENTRY] || rate_q[LANE_ENTRY] >= rate_side.cap) begin
      er_next = rate_side.cap;
    end else begin
      er_next = rate_q[LANE_ENTRY];
    end
    if (rate_ovf[LANE_EXIT] || rate_q[LANE_EXIT] >= rate_side.cap) begin
      xr_next = rate_side.cap;
    end else begin
      xr_next = rate_q[LANE_EXIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
    end else if (en) begin
      b3_valid <= rate_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_er   <= er_next;
      b3_xr   <= xr_next;
      b3_pos  <= MEET_W'({rate_side.a_s, {ACC_SHIFT{1'b0}}}) + MEET_W'(xr_next);
      b3_side <= rate_side;
    end
  end

  // Stage 4: ramp numerators; drop a non-positive meeting numerator to zero
  logic                                  b4_valid;
  logic [RAMP_LANES-1:0][RAMP_NUM_W-1:0] b4_num;
  logic [RAMP_DIV_W-1:0]                 b4_div;
  ramp_side_t                            b4_side;
  ramp_side_t                            b4_side_next;
  logic [MEET_W:0]                       meet_diff;

  assign meet_diff = {1'b0, b3_pos} - (MEET_W + 1)'(b3_er);

  always_comb begin
    b4_side_next.steps    = b3_side.steps;
    b4_side_next.axis     = b3_side.axis;
    b4_side_next.len_zero = b3_side.len_zero;
    b4_side_next.er       = b3_er;
    b4_side_next.xr       = b3_xr;
    b4_side_next.acc_zero = (b3_side.accel == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_valid <= 1'b0;
    end else if (en) begin
      b4_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4_num[LANE_UP]   <= RAMP_NUM_W'(b3_side.cap - b3_er);
      b4_num[LANE_DOWN] <= RAMP_NUM_W'(b3_side.cap - b3_xr);
      if (meet_diff[MEET_W]) begin
        b4_num[LANE_MEET] <= '0;
      end else begin
        // Halve: dividing by accel*1024 equals halving, then dividing by accel*512
        b4_num[LANE_MEET] <= meet_diff[MEET_W-1:1];
      end
      b4_div  <= {b3_side.accel, {ACC_SHIFT{1'b0}}};
      b4_side <= b4_side_next;
    end
  end

  // Ramp division by accel*512: accel ramp, decel ramp, meeting point
  logic                                ramp_valid;
  logic [RAMP_LANES-1:0][RAMP_Q_W-1:0] ramp_q;
  logic [RAMP_LANES-1:0]               ramp_ovf;
  logic [RAMP_LANES-1:0]               ramp_rnz;
  ramp_side_t                          ramp_side;

  tsp_div #(
    .LANES (RAMP_LANES),
    .NW    (RAMP_NUM_W),
    .DW    (RAMP_DIV_W),
    .QW    (RAMP_Q_W),
    .SW    ($bits(ramp_side_t))
  ) u_ramp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b4_valid),
    .dividend  (b4_num),
    .divisor   (b4_div),
    .in_side   (b4_side),
    .out_valid (ramp_valid),
    .quot      (ramp_q),
    .ovf       (ramp_ovf),
    .rem_nz    (ramp_rnz),
    .out_side  (ramp_side)
  );

  // Stage 5: round the accel ramp up; zero acceleration gives no ramps
  logic                b5_valid;
  logic [RAMP_Q_W:0]   b5_up;
  logic [RAMP_Q_W-1:0] b5_down;
  logic [RAMP_Q_W-1:0] b5_meet;
  ramp_side_t          b5_side;
  logic                ramp_off;

  // Overflow only arises from a zero divisor
  assign ramp_off = ramp_side.acc_zero || (|ramp_ovf);

  always_ff @(posedge clk) begin
    if (rst) begin
      b5_valid <= 1'b0;
    end else if (en) begin
      b5_valid <= ramp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ramp_off) begin
        b5_up   <= '0;
        b5_down <= '0;
        b5_meet <= '0;
      end else begin
        b5_up   <= {1'b0, ramp_q[LANE_UP]} + (RAMP_Q_W + 1)'(ramp_rnz[LANE_UP]);
        b5_down <= ramp_q[LANE_DOWN];
        b5_meet <= ramp_q[LANE_MEET];
      end
      b5_side <= ramp_side;
    end
  end

  // Output stage: pick plateau bounds, use the meeting point when no plateau remains
  logic [RAMP_Q_W+1:0] ramp_sum;
  logic                no_plateau;
  logic [STEP_W-1:0]   meet_clamped;
  logic [STEP_W-1:0]   pstart_next;
  logic [STEP_W-1:0]   dstart_next;

  assign ramp_sum     = (RAMP_Q_W + 2)'(b5_up) + (RAMP_Q_W + 2)'(b5_down);
  assign no_plateau   = (ramp_sum > (RAMP_Q_W + 2)'(b5_side.steps));
  assign meet_clamped = (b5_meet < RAMP_Q_W'(b5_side.steps)) ? b5_meet[STEP_W-1:0]
                                                             : b5_side.steps;

  always_comb begin
    if (no_plateau) begin
      pstart_next = meet_clamped;
      dstart_next = meet_clamped;
    end else begin
      pstart_next = b5_up[STEP_W-1:0];
      dstart_next = b5_side.steps - b5_down[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && b5_valid) begin
      if (b5_side.len_zero) begin
        longest_axis       <= '0;
        plateau_start_step <= '0;
        decel_start_step   <= '0;
        entry_rate_sqr     <= '0;
        exit_rate_sqr      <= '0;
        length_error       <= 1'b1;
      end else begin
        longest_axis       <= b5_side.axis;
        plateau_start_step <= pstart_next;
        decel_start_step   <= dstart_next;
        entry_rate_sqr     <= b5_side.er;
        exit_rate_sqr      <= b5_side.xr;
        length_error       <= 1'b0;
      end
    end
  end

  // Clamped rates never exceed the cap
  a_rate_capped: assert property (@(posedge clk) disable iff (rst)
    b3_valid |-> (b3_er <= b3_side.cap) && (b3_xr <= b3_side.cap))
    else $error("clamped rate above nominal cap");

  // Deceleration never starts before the plateau
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !length_error |-> decel_start_step >= plateau_start_step)
    else $error("decel start precedes plateau start");

  // A zero-length segment reports nothing but the flag
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> longest_axis == '0 && plateau_start_step == '0 &&
      decel_start_step == '0 && entry_rate_sqr == '0 && exit_rate_sqr == '0)
    else $error("zero-length segment carries nonzero fields");

  // Every ramp divider result taken while the pipeline moves reaches stage 5
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    en && ramp_valid |=> b5_valid)
    else $error("ramp result lost between divider and stage 5");

endmodule

[rtl/trapezoid_step_profile_core.sv]
`timescale 1ns / 1ps
// Trapezoid step profile planner: one motion segment in, one step profile out.
// Throughput: one segment per cycle unless out_ready stalls the output; set by the two bit-per-stage divider pipelines
// (48 stages for the squared rates, 39 for the ramp lengths).
// Reset: rst clears all valid flags and the queue; no results are pending after it.
// Depends on tsp_pkg, tsp_front, tsp_queue, tsp_div, tsp_back.
module trapezoid_step_profile_core #(
  parameter int AXES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tsp_pkg::STEP_W-1:0] axis0_steps,
  input  logic [tsp_pkg::STEP_W-1:0] axis1_steps,
  input  logic [tsp_pkg::STEP_W-1:0] axis2_steps,
  input  logic [tsp_pkg::STEP_W-1:0] axis3_steps,
  input  logic [tsp_pkg::LEN_W-1:0]  line_length,
  input  logic [tsp_pkg::SPD_W-1:0]  entry_speed_sqr,
  input  logic [tsp_pkg::SPD_W-1:0]  exit_speed_sqr,
  input  logic [tsp_pkg::NOM_W-1:0]  nominal_rate,
  input  logic [tsp_pkg::ACC_W-1:0]  accel_rate,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tsp_pkg::AXIS_W-1:0] longest_axis,
  output logic [tsp_pkg::STEP_W-1:0] plateau_start_step,
  output logic [tsp_pkg::STEP_W-1:0] decel_start_step,
  output logic [tsp_pkg::RATE_W-1:0] entry_rate_sqr,
  output logic [tsp_pkg::RATE_W-1:0] exit_rate_sqr,
  output logic                       length_error
);
  import tsp_pkg::*;

  logic fr_valid;
  logic fr_ready;
  seg_t fr_seg;
  logic bk_valid;
  logic bk_ready;
  seg_t bk_seg;

  // Accept and classify
  tsp_front #(
    .AXES (AXES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .axis0_steps     (axis0_steps),
    .axis1_steps     (axis1_steps),
    .axis2_steps     (axis2_steps),
    .axis3_steps     (axis3_steps),
    .line_length     (line_length),
    .entry_speed_sqr (entry_speed_sqr),
    .exit_speed_sqr  (exit_speed_sqr),
    .nominal_rate    (nominal_rate),
    .accel_rate      (accel_rate),
    .seg_valid       (fr_valid),
    .seg_ready       (fr_ready),
    .seg             (fr_seg)
  );

  // Decouple front and back
  tsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_seg),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_seg)
  );

  // Compute the profile
  tsp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (bk_valid),
    .in_ready           (bk_ready),
    .seg                (bk_seg),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .longest_axis       (longest_axis),
    .plateau_start_step (plateau_start_step),
    .decel_start_step   (decel_start_step),
    .entry_rate_sqr     (entry_rate_sqr),
    .exit_rate_sqr      (exit_rate_sqr),
    .length_error       (length_error)
  );

endmodule
